### rtl/mbf_pkg.sv
// Metaball field renderer: shared types, constants and state codes.
// No dependencies; compiled first.
package mbf_pkg;

	localparam int unsigned POS_W    = 14;
	localparam int unsigned RAD_W    = 13;
	localparam int unsigned VEL_W    = 16;
	localparam int unsigned MS_W     = 10;
	localparam int unsigned PIX_W    = 10;
	localparam int unsigned SIZE_W   = 11;
	localparam int unsigned ACT_W    = 5;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned BIDX_W   = 4;
	localparam int unsigned FIELD_W  = 32;
	localparam int unsigned GRAD_W   = 8;
	localparam int unsigned FRAC_BITS = 4;
	localparam int unsigned CFG_IDX_W = 2;

	// shared divider widths
	localparam int unsigned DIV_NW  = 42;
	localparam int unsigned DIV_DW  = 32;
	localparam int unsigned DIV_CW  = 6;

	// tick scaling: |v*ms| < 2^25, so ceil(2^35/1000) gives an exact floor(x/1000)
	localparam logic [25:0]        TICK_RECIP   = 26'd34359739;
	localparam int unsigned        TICK_SHIFT   = 35;
	localparam logic [FIELD_W-1:0] FIELD_ONE    = 32'h0001_0000;
	localparam logic [FIELD_W-1:0] FIELD_SAT    = 32'hFFFF_FFFF;
	localparam logic [POS_W-1:0]   POS_MAX      = 14'h3FFF;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_TICK  = 2'd1,
		OP_PIXEL = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_ACTIVE      = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0]        px;
		logic [POS_W-1:0]        py;
		logic [RAD_W-1:0]        r;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
	} ball_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_LOAD,
		ST_MUL,
		ST_DSTART,
		ST_DWAIT,
		ST_UPDATE,
		ST_WRITE,
		ST_NEXT,
		ST_GSTART,
		ST_GWAIT,
		ST_FINISH
	} state_t;

endpackage

### rtl/mbf_if.sv
// Metaball field renderer: valid/ready channel interfaces for input and result words.
// Depends on mbf_pkg.
interface mbf_in_if;
	logic                                     valid;
	logic                                     ready;
	logic [mbf_pkg::OP_W-1:0]                 opcode;
	logic [mbf_pkg::BIDX_W-1:0]               ball_index;
	logic [mbf_pkg::POS_W-1:0]                ball_x;
	logic [mbf_pkg::POS_W-1:0]                ball_y;
	logic [mbf_pkg::RAD_W-1:0]                ball_radius;
	logic signed [mbf_pkg::VEL_W-1:0]         vel_x;
	logic signed [mbf_pkg::VEL_W-1:0]         vel_y;
	logic [mbf_pkg::MS_W-1:0]                 tick_ms;
	logic [mbf_pkg::PIX_W-1:0]                pixel_x;
	logic [mbf_pkg::PIX_W-1:0]                pixel_y;

	modport source (output valid, opcode, ball_index, ball_x, ball_y, ball_radius,
		vel_x, vel_y, tick_ms, pixel_x, pixel_y, input ready);
	modport sink (input valid, opcode, ball_index, ball_x, ball_y, ball_radius,
		vel_x, vel_y, tick_ms, pixel_x, pixel_y, output ready);
endinterface

interface mbf_out_if;
	logic                           valid;
	logic                           ready;
	logic [mbf_pkg::FIELD_W-1:0]    field_sum;
	logic                           covered;
	logic [mbf_pkg::GRAD_W-1:0]     gradient_index;

	modport source (output valid, field_sum, covered, gradient_index, input ready);
	modport sink (input valid, field_sum, covered, gradient_index, output ready);
endinterface

### rtl/mbf_div.sv
// Metaball field renderer: restoring divider, one quotient bit per cycle.
// Depends on mbf_pkg. Shared by field terms and gradient index.
module mbf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mbf_pkg::DIV_NW-1:0] dividend,
	input  logic [mbf_pkg::DIV_DW-1:0] divisor,
	output logic                       done,
	output logic [mbf_pkg::DIV_NW-1:0] quotient
);
	import mbf_pkg::*;

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   rem_sh;
	logic              fits;

	assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_DW'(rem_sh - {1'b0, dvs_q});
			end else begin
				rem_q <= rem_sh[DIV_DW-1:0];
			end
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### rtl/metaball_field_renderer.sv
// Metaball field renderer top level: ball table memory, sequencer, result register.
// Depends on mbf_pkg, mbf_if (mbf_in_if, mbf_out_if) and mbf_div.
//
// Use: input words arrive on in_ch (valid/ready). opcode write loads one table
// entry in the accepting cycle; tick moves the active balls; pixel sums
// r^2/d^2 over the active balls and returns one word on out_ch with the Q16.16
// sum, the covered flag and the gradient index. Write and tick return nothing.
// Config (grid_width, grid_height, active_balls) goes through cfg_we/cfg_index/
// cfg_data, which the user must write only while the block is idle (not enforced).
// Sequencing: field terms and the gradient index go through one shared
// 42-step radix-2 divider; tick scaling by 1/1000 is a reciprocal multiply.
//   tick: each active ball (N = min(active_balls, MAX_BALLS)) is moved on x,
//   then on y; a ball with zero velocity is skipped. pixel: one divide per
//   active ball, plus one for the gradient when covered; a ball sitting
//   exactly on the pixel skips its divide.
// One item is in work at a time; ready is high only between items.
// The result sits in an output register, so the next word is taken while
// a result waits; a pixel that finishes while that register is still full
// holds in its last step until the receiver takes the old word.
// Reset: registers return to 256/256/0, the sequencer idles, out_ch empties.
// The ball table is not cleared; entries read before being written are
// undefined.
module metaball_field_renderer #(
	parameter int unsigned MAX_BALLS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mbf_in_if.sink                        in_ch,
	mbf_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [mbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbf_pkg::SIZE_W-1:0]    cfg_data
);
	import mbf_pkg::*;

	localparam int unsigned IW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
	localparam int unsigned CW = $clog2(MAX_BALLS + 1);

	// configuration
	logic [SIZE_W-1:0] gw_q, gh_q;
	logic [ACT_W-1:0]  act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q  <= SIZE_W'(256);
			gh_q  <= SIZE_W'(256);
			act_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GRID_WIDTH:  gw_q  <= cfg_data;
				CFG_GRID_HEIGHT: gh_q  <= cfg_data;
				CFG_ACTIVE:      act_q <= cfg_data[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] cnt;
	assign cnt = (32'(act_q) > MAX_BALLS) ? CW'(MAX_BALLS) : CW'(act_q);

	// sequencer state and working registers
	state_t state_q, state_d;
	logic                    op_pix_q;
	logic                    axis_q;
	logic [CW-1:0]           idx_q;
	logic [MS_W-1:0]         ms_q;
	logic [PIX_W-1:0]        pxl_x_q, pxl_y_q;
	ball_t                   ent_q;
	logic signed [26:0]      prod_q;
	logic [16:0]             tq_q;
	logic [29:0]             dx2_q, dy2_q;
	logic [2*RAD_W-1:0]      r2_q;
	logic [FIELD_W-1:0]      sum_q;

	// result register
	logic                    out_valid_q;
	logic [FIELD_W-1:0]      out_sum_q;
	logic                    out_cov_q;
	logic [GRAD_W-1:0]       out_grad_q;

	// table memory, registered read
	ball_t                   mem_q [MAX_BALLS];
	ball_t                   rd_q;
	logic                    mem_we;
	logic [IW-1:0]           mem_wa;
	ball_t                   mem_wd;

	logic                    in_acc;
	logic                    div_start, div_done;
	logic [DIV_NW-1:0]       div_n, div_q;
	logic [DIV_DW-1:0]       div_d;
	logic                    out_free;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[idx_q[IW-1:0]];
	end

	// pixel distance terms
	logic signed [POS_W:0]   dx, dy;
	logic [30:0]             d2;
	assign dx = $signed({1'b0, pxl_x_q, {FRAC_BITS{1'b0}}}) - $signed({1'b0, ent_q.px});
	assign dy = $signed({1'b0, pxl_y_q, {FRAC_BITS{1'b0}}}) - $signed({1'b0, ent_q.py});
	assign d2 = 31'(dx2_q) + 31'(dy2_q);

	// tick: magnitude of v*ms, then floor(|v*ms|/1000) by reciprocal
	logic [26:0]             prod_mag;
	logic [51:0]             tprod;
	assign prod_mag = prod_q[26] ? 27'(-prod_q) : 27'(prod_q);
	assign tprod    = prod_mag[24:0] * TICK_RECIP;

	// gradient numerator (F - 1.0) * 255
	logic [FIELD_W-1:0]      gdiff;
	logic [FIELD_W+7:0]      gnum;
	assign gdiff = sum_q - FIELD_ONE;
	assign gnum  = {gdiff, 8'b0} - (FIELD_W + 8)'(gdiff);

	// one axis of motion with bounce
	logic [POS_W-1:0]        a_pos;
	logic signed [VEL_W-1:0] a_vel;
	logic [SIZE_W-1:0]       a_size;
	logic signed [19:0]      a_delta, a_p, a_r, a_edge, a_hi, a_pc;
	logic                    a_hit;
	logic signed [VEL_W-1:0] a_vnew;
	logic [POS_W-1:0]        a_pnew;

	always_comb begin
		a_pos   = axis_q ? ent_q.py : ent_q.px;
		a_vel   = axis_q ? ent_q.vy : ent_q.vx;
		a_size  = axis_q ? gh_q : gw_q;
		a_delta = prod_q[26] ? -$signed(20'(tq_q)) : $signed(20'(tq_q));
		a_p     = $signed(20'(a_pos)) + a_delta;
		a_r     = $signed(20'(ent_q.r));
		a_edge  = $signed(20'({a_size, {FRAC_BITS{1'b0}}}));
		a_hi    = a_edge - a_r;
		a_hit   = (a_p - a_r < 0) || (a_p + a_r >= a_edge);
		a_vnew  = a_vel;
		a_pc    = a_p;
		if (a_hit) begin
			a_vnew = (a_vel == -16'sd32768) ? 16'sd32767 : -a_vel;
			if (a_p < a_r) begin
				a_pc = a_r;
			end else if (a_p > a_hi) begin
				a_pc = a_hi;
			end
		end
		if (a_pc < 0) begin
			a_pnew = '0;
		end else if (a_pc > $signed(20'(POS_MAX))) begin
			a_pnew = POS_MAX;
		end else begin
			a_pnew = a_pc[POS_W-1:0];
		end
	end

	mbf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (op_t'(in_ch.opcode) == OP_TICK
						|| op_t'(in_ch.opcode) == OP_PIXEL)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK:  state_d = (idx_q == cnt) ? (op_pix_q ? ST_GSTART : ST_IDLE) : ST_READ;
			ST_READ:   state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_MUL;
			ST_MUL: begin
				if (!op_pix_q && ent_q.vx == '0 && ent_q.vy == '0) begin
					state_d = ST_NEXT;
				end else begin
					state_d = ST_DSTART;
				end
			end
			ST_DSTART: begin
				if (op_pix_q) begin
					state_d = (d2 == '0) ? ST_NEXT : ST_DWAIT;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_DWAIT:  state_d = div_done ? ST_UPDATE : ST_DWAIT;
			ST_UPDATE: begin
				if (op_pix_q) begin
					state_d = ST_NEXT;
				end else begin
					state_d = axis_q ? ST_WRITE : ST_MUL;
				end
			end
			ST_WRITE:  state_d = ST_NEXT;
			ST_NEXT:   state_d = ST_CHECK;
			ST_GSTART: state_d = (sum_q < FIELD_ONE) ? ST_FINISH : ST_GWAIT;
			ST_GWAIT:  state_d = div_done ? ST_FINISH : ST_GWAIT;
			ST_FINISH: state_d = out_free ? ST_IDLE : ST_FINISH;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		div_start   = 1'b0;
		div_n       = '0;
		div_d       = '0;
		mem_we      = 1'b0;
		mem_wa      = idx_q[IW-1:0];
		mem_wd      = ent_q;
		case (state_q)
			ST_IDLE: begin
				mem_wa = IW'(in_ch.ball_index);
				mem_wd = '{px: in_ch.ball_x, py: in_ch.ball_y, r: in_ch.ball_radius,
					vx: in_ch.vel_x, vy: in_ch.vel_y};
				mem_we = in_acc && op_t'(in_ch.opcode) == OP_WRITE
					&& 32'(in_ch.ball_index) < MAX_BALLS;
			end
			ST_DSTART: begin
				if (op_pix_q) begin
					div_start = (d2 != '0);
					div_n     = {r2_q, 16'b0};
					div_d     = DIV_DW'(d2);
				end
			end
			ST_GSTART: begin
				div_start = (sum_q >= FIELD_ONE);
				div_n     = DIV_NW'(gnum);
				div_d     = sum_q;
			end
			ST_WRITE: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			axis_q      <= 1'b0;
			op_pix_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new result loads as the old one leaves; otherwise a taken word empties
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q    <= '0;
					axis_q   <= 1'b0;
					op_pix_q <= (op_t'(in_ch.opcode) == OP_PIXEL);
				end
				ST_UPDATE: if (!op_pix_q) axis_q <= ~axis_q;
				ST_NEXT: begin
					idx_q  <= idx_q + 1'b1;
					axis_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ms_q    <= in_ch.tick_ms;
				pxl_x_q <= in_ch.pixel_x;
				pxl_y_q <= in_ch.pixel_y;
				sum_q   <= '0;
			end
			ST_LOAD: ent_q <= rd_q;
			ST_MUL: begin
				prod_q <= (axis_q ? ent_q.vy : ent_q.vx) * $signed({1'b0, ms_q});
				dx2_q  <= 30'(dx * dx);
				dy2_q  <= 30'(dy * dy);
				r2_q   <= ent_q.r * ent_q.r;
			end
			ST_DSTART: begin
				if (!op_pix_q) begin
					tq_q <= tprod[TICK_SHIFT+16:TICK_SHIFT];
				end
			end
			ST_UPDATE: begin
				if (op_pix_q) begin
					if (div_q[DIV_NW-1:FIELD_W] != '0
							|| 33'(sum_q) + 33'(div_q[FIELD_W-1:0]) > 33'(FIELD_SAT)) begin
						sum_q <= FIELD_SAT;
					end else begin
						sum_q <= sum_q + div_q[FIELD_W-1:0];
					end
				end else if (axis_q) begin
					ent_q.py <= a_pnew;
					ent_q.vy <= a_vnew;
				end else begin
					ent_q.px <= a_pnew;
					ent_q.vx <= a_vnew;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_sum_q  <= sum_q;
					out_cov_q  <= (sum_q >= FIELD_ONE);
					out_grad_q <= (sum_q >= FIELD_ONE) ? div_q[GRAD_W-1:0] : '0;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.field_sum      = out_sum_q;
	assign out_ch.covered        = out_cov_q;
	assign out_ch.gradient_index = out_grad_q;
endmodule
